// ===== rtl/pld_pkg.sv =====
package pld_pkg;

    localparam int FIELD_W = 16;
    localparam int AGE_W   = 16;
    localparam int TICKS_W = 15;
    localparam int FUNC_W  = 2;

    localparam logic [TICKS_W-1:0] STABLE_TICKS_RESET = 15'd100;
    localparam logic [AGE_W-1:0]   AGE_MAX            = 16'hFFFF;

    localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SAMPLE   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_BASELINE = 2'd2;

    // Decoded per-beat command shared by every lane.
    typedef struct packed {
        logic accept;
        logic tick;
        logic sample;
        logic baseline;
    } lane_ctrl_t;

endpackage

// ===== rtl/pld_item_if.sv =====
interface pld_item_if;
    logic                              valid;
    logic                              ready;
    logic [pld_pkg::FUNC_W-1:0]        func;
    logic [pld_pkg::FIELD_W-1:0]       status_bits;

    modport source (output valid, output func, output status_bits, input ready);
    modport sink   (input valid, input func, input status_bits, output ready);
endinterface

// ===== rtl/pld_result_if.sv =====
interface pld_result_if;
    logic                              valid;
    logic                              ready;
    logic [pld_pkg::FIELD_W-1:0]       stable_bits;
    logic [pld_pkg::FIELD_W-1:0]       current_statuses;
    logic                              any_stable;

    modport source (output valid, output stable_bits, output current_statuses,
                    output any_stable, input ready);
    modport sink   (input valid, input stable_bits, input current_statuses,
                    input any_stable, output ready);
endinterface

// ===== rtl/pld_cfg_if.sv =====
interface pld_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [pld_pkg::TICKS_W-1:0]       data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/pld_lane.sv =====
module pld_lane (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pld_pkg::lane_ctrl_t           ctrl,
    input  logic                          sample_bit,
    input  logic [pld_pkg::TICKS_W-1:0]   stable_ticks,
    output logic                          stable_bit,
    output logic                          status_bit
);

    logic [pld_pkg::AGE_W-1:0] age_reg;
    logic [pld_pkg::AGE_W-1:0] age_next;
    logic                      flag_reg;
    logic                      flag_next;
    logic                      last_reg;
    logic                      last_next;
    logic                      flag_mid;
    logic                      changed;

    // Update the line first, then check it against the window.
    always_comb
    begin
        age_next  = age_reg;
        flag_mid  = flag_reg;
        last_next = last_reg;
        changed   = sample_bit ^ last_reg;
        if (ctrl.tick)
        begin
            if (age_reg != pld_pkg::AGE_MAX)
            begin
                age_next = age_reg + {{(pld_pkg::AGE_W-1){1'b0}}, 1'b1};
            end
        end
        else if (ctrl.sample)
        begin
            last_next = sample_bit;
            if (changed)
            begin
                age_next = '0;
                flag_mid = ~flag_reg;
            end
        end
        else if (ctrl.baseline)
        begin
            last_next = sample_bit;
        end
        stable_bit = flag_mid && (age_next > {1'b0, stable_ticks});
        flag_next  = flag_mid & ~stable_bit;
    end

    assign status_bit = last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_reg  <= '0;
            flag_reg <= 1'b0;
            last_reg <= 1'b0;
        end
        else if (ctrl.accept)
        begin
            age_reg  <= age_next;
            flag_reg <= flag_next;
            last_reg <= last_next;
        end
    end

endmodule

// ===== rtl/pld_merge.sv =====
module pld_merge #(
    parameter int LINES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [LINES-1:0]   lane_stable,
    input  logic [LINES-1:0]   lane_status,
    pld_result_if.source       result
);

    logic [pld_pkg::FIELD_W-1:0] stable_word;
    logic [pld_pkg::FIELD_W-1:0] status_word;
    logic                        valid_reg;
    logic                        valid_next;
    logic [pld_pkg::FIELD_W-1:0] stable_reg;
    logic [pld_pkg::FIELD_W-1:0] status_reg;
    logic                        any_reg;

    // Only the low lines reach the result fields; missing lines read as zero.
    always_comb
    begin
        stable_word = '0;
        status_word = '0;
        for (int j = 0; j < pld_pkg::FIELD_W; j++)
        begin
            if (j < LINES)
            begin
                stable_word[j] = lane_stable[j];
                status_word[j] = lane_status[j];
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stable_reg <= stable_word;
            status_reg <= status_word;
            any_reg    <= |stable_word;
        end
    end

    assign result.valid            = valid_reg;
    assign result.stable_bits      = stable_reg;
    assign result.current_statuses = status_reg;
    assign result.any_stable       = any_reg;

endmodule

// ===== rtl/per_line_interrupt_debouncer_core.sv =====
// A result beat is registered and presented in the cycle after its item beat is accepted.
// Throughput: one item per cycle while results are taken; every line lane updates its age, flag and
// status in the accepting cycle, so the next item sees the new state at once.
// The result register stalls intake only while it is full and not being taken.
// Reset (rst_n, asynchronous, active low) clears all lanes and sets the window to 100.
module per_line_interrupt_debouncer_core #(
    parameter int LINES = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    pld_item_if.sink      item,
    pld_result_if.source  result,
    pld_cfg_if.sink       cfg
);

    // Window register. Writes are always taken; the block is assumed idle
    // whenever software changes it.
    logic [pld_pkg::TICKS_W-1:0] stable_ticks_reg;
    logic [pld_pkg::TICKS_W-1:0] stable_ticks_next;

    pld_pkg::lane_ctrl_t ctrl;
    logic [LINES-1:0]    lane_stable;
    logic [LINES-1:0]    lane_status;
    logic                accept;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        stable_ticks_next = stable_ticks_reg;
        if (cfg.valid)
        begin
            stable_ticks_next = cfg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_ticks_reg <= pld_pkg::STABLE_TICKS_RESET;
        end
        else
        begin
            stable_ticks_reg <= stable_ticks_next;
        end
    end

    // An item enters whenever the result register is empty or is being
    // drained in this same cycle.
    assign item.ready = ~result.valid | result.ready;
    assign accept     = item.valid & item.ready;

    // Decode the command once and broadcast it to every lane. The unused code leaves
    // age and status untouched, but the window check still runs and may clear the flag.
    always_comb
    begin
        ctrl.accept   = accept;
        ctrl.tick     = 1'b0;
        ctrl.sample   = 1'b0;
        ctrl.baseline = 1'b0;
        case (item.func)
            pld_pkg::FUNC_TICK:     ctrl.tick     = 1'b1;
            pld_pkg::FUNC_SAMPLE:   ctrl.sample   = 1'b1;
            pld_pkg::FUNC_BASELINE: ctrl.baseline = 1'b1;
            default:                ctrl.tick     = 1'b0;
        endcase
    end

    // One lane per interrupt line. Lines above the status word width see a
    // constant zero sample and therefore never toggle their status or flag.
    for (genvar i = 0; i < LINES; i++)
    begin : g_lane
        logic sample_bit;
        if (i < pld_pkg::FIELD_W)
        begin : g_in
            assign sample_bit = item.status_bits[i];
        end
        else
        begin : g_zero
            assign sample_bit = 1'b0;
        end

        pld_lane u_lane (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .sample_bit   (sample_bit),
            .stable_ticks (stable_ticks_reg),
            .stable_bit   (lane_stable[i]),
            .status_bit   (lane_status[i])
        );
    end

    // Gather the lane findings into the registered result beat.
    pld_merge #(
        .LINES (LINES)
    ) u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .lane_stable (lane_stable),
        .lane_status (lane_status),
        .result      (result)
    );

endmodule
